// ===== sv/smpf_pkg.sv =====
// Package for the smallest prime factor divider.
// Holds the default value width and the state codes of the top-level sequencer.
// No dependencies.
`timescale 1ns / 1ps

package smpf_pkg;

  localparam int ValueWidthDef = 32;

  localparam int StateWidth = 2;
  localparam logic [StateWidth-1:0] StIdle = 2'd0;
  localparam logic [StateWidth-1:0] StDiv  = 2'd1;
  localparam logic [StateWidth-1:0] StPush = 2'd2;

endpackage

// ===== sv/smpf_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses smpf_pkg for the default width. The divisor must stay stable while busy.
`timescale 1ns / 1ps

module smpf_divider import smpf_pkg::*; #(
  parameter int Width = ValueWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o,
  output logic [Width-1:0] remainder_o
);

  localparam int CntWidth = $clog2(Width);
  localparam logic [CntWidth-1:0] LastCnt = CntWidth'(Width - 1);

  logic             busy_q;
  logic             done_q;
  logic [CntWidth-1:0] cnt_q;
  logic [Width-1:0] rem_q;
  logic [Width-1:0] quo_q;

  logic [Width:0] shifted;
  logic [Width:0] diff;
  logic           fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q, quo_q[Width-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign fits    = ~diff[Width];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntWidth'(1);
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[Width-1:0] : shifted[Width-1:0];
      quo_q <= {quo_q[Width-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== sv/smallest_prime_factor_divide.sv =====
// Smallest prime factor divider. Takes a word n and returns n divided by its smallest
// prime factor p, together with p; n below 2 comes back unchanged with a factor of 0,
// and a prime n gives p = n and a quotient of 1. One word is worked on at a time.
// Even words and words below 2 skip the divider and go straight to the push state. Odd
// words go through trial division by 3, 5, 7, ... in the bit-serial divider, one
// candidate after the other; a 32-bit prime near the top of the range needs about
// 32768 candidates. A finished result sits in the output register, so the next word
// is taken while it waits. Depends on smpf_pkg and smpf_divider.
`timescale 1ns / 1ps

module smallest_prime_factor_divide import smpf_pkg::*; #(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] smallest_factor_o
);

  localparam logic [VALUE_WIDTH-1:0] One = VALUE_WIDTH'(1);
  localparam logic [VALUE_WIDTH-1:0] Two = VALUE_WIDTH'(2);
  localparam logic [VALUE_WIDTH-1:0] Three = VALUE_WIDTH'(3);

  logic [StateWidth-1:0]  state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] cand_q, cand_d;
  logic [VALUE_WIDTH-1:0] res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] quot_out_q, quot_out_d;
  logic [VALUE_WIDTH-1:0] fac_out_q, fac_out_d;

  logic                   in_fire;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [VALUE_WIDTH-1:0] div_rem;
  logic                   out_free;

  smpf_divider #(
    .Width(VALUE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_d),
    .divisor_i  (cand_d),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cand_d      = cand_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    quot_out_d  = quot_out_q;
    fac_out_d   = fac_out_q;
    div_start   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          n_d = value_i;
          priority if (value_i < Two) begin
            res_d   = value_i;
            cand_d  = '0;
            state_d = StPush;
          end else if (!value_i[0]) begin
            res_d   = value_i >> 1;
            cand_d  = Two;
            state_d = StPush;
          end else begin
            cand_d    = Three;
            div_start = 1'b1;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          // The loop runs only while the candidate is at most n / candidate.
          priority if (cand_q > div_quot) begin
            res_d   = One;
            cand_d  = n_q;
            state_d = StPush;
          end else if (div_rem == '0) begin
            res_d   = div_quot;
            state_d = StPush;
          end else begin
            cand_d    = cand_q + Two;
            div_start = 1'b1;
          end
        end
      end
      StPush: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          quot_out_d  = res_q;
          fac_out_d   = cand_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    cand_q     <= cand_d;
    res_q      <= res_d;
    quot_out_q <= quot_out_d;
    fac_out_q  <= fac_out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign quotient_o        = quot_out_q;
  assign smallest_factor_o = fac_out_q;

  // Trial divisors are always odd while the divider is running.
  a_cand_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> cand_q[0])
    else $error("even trial divisor during division");

  // The divider only finishes while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider finished outside the division state");

  // Words below 2 skip the divider and report a factor of 0.
  a_small_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (value_i < Two)) |=> ((state_q == StPush) && (cand_q == '0)))
    else $error("small word not passed straight through");

  // A finished result waits while the output register is still occupied.
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StPush) && out_valid_q && !out_ready_i) |=> (state_q == StPush))
    else $error("result dropped while output stalled");

  // Loading the output register always raises its valid flag.
  a_push_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StPush) && out_free) |=> (out_valid_q && (state_q == StIdle)))
    else $error("result not delivered to output register");

endmodule

// ===== tb/smallest_prime_factor_divide_test.sv =====
// Self-checking testbench for the smallest prime factor divider: directed and random words,
// idle gaps on both sides, a long output hold-off and an input pause, all checked in order.
// Depends on smpf_pkg and smallest_prime_factor_divide.
`timescale 1ns / 1ps

module smallest_prime_factor_divide_test;
  import smpf_pkg::*;

  localparam int ValueWidth = ValueWidthDef;
  localparam int unsigned CycleLimit = 10_000_000;
  localparam int HoldOffCycles = 400;
  localparam int RandomWords = 70;

  typedef logic [ValueWidth-1:0] value_t;

  typedef struct {
    value_t value;
    value_t quotient;
    value_t factor;
  } split_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  value_t value_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  value_t quotient_o;
  value_t smallest_factor_o;

  split_t      expected_splits[$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  int          rx_hold_request = 0;

  smallest_prime_factor_divide #(
    .VALUE_WIDTH(ValueWidth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quotient_o       (quotient_o),
    .smallest_factor_o(smallest_factor_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Trial division by 2, then by odd candidates up to the square root.
  function automatic split_t divide_out_smallest(value_t n);
    split_t          r;
    longint unsigned nn;
    longint unsigned cand;
    longint unsigned p;
    bit              found;
    nn = n;
    r.value = n;
    if (nn < 2) begin
      r.quotient = n;
      r.factor = '0;
      return r;
    end
    if (nn % 2 == 0) begin
      p = 2;
    end else begin
      p = nn;
      cand = 3;
      found = 1'b0;
      while (!found && cand <= nn / cand) begin
        if (nn % cand == 0) begin
          p = cand;
          found = 1'b1;
        end else begin
          cand += 2;
        end
      end
    end
    r.quotient = value_t'(nn / p);
    r.factor = value_t'(p);
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string field, value_t value, value_t got, value_t want);
    $display("mismatch: %s for value %0d: got %0d, expected %0d", field, value, got, want);
    mismatch_count++;
  endtask

  // Offers one word and returns at the edge where it is accepted.
  task automatic offer_value(value_t v);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    expected_splits.push_back(divide_out_smallest(v));
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_splits.size() > 0) @(posedge clk_i);
  endtask

  // Mostly well-formed products with a small factor, so trial division stays short.
  function automatic value_t random_value();
    int unsigned factor;
    int unsigned k;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      factor = $urandom_range(2, 200);
      if ($urandom_range(0, 9) == 0) k = 1;
      else k = $urandom_range(1, 32'hFFFF_FFFF / factor);
      return value_t'(factor * k);
    end
    if (r < 80) return value_t'({$urandom()} & 32'hFFFF_FFFE);
    return value_t'($urandom_range(0, 32'h0000_FFFF));
  endfunction

  task automatic test_directed_values();
    value_t directed[$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd63001,
                 32'd65521, 32'd1000003, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'd4294966913};
    no_idle = 1'b1;
    foreach (directed[i]) begin
      if (i == 8) no_idle = 1'b0;
      offer_value(directed[i]);
    end
    wait_drained();
  endtask

  task automatic test_sender_pause();
    repeat (5) offer_value(random_value());
    wait_drained();
    repeat (5) offer_value(random_value());
    wait_drained();
  endtask

  // Even words skip the divider, so the block fills and stalls its input
  // while the output is held off.
  task automatic test_output_hold_off();
    no_idle = 1'b1;
    rx_hold_request = HoldOffCycles;
    repeat (6) offer_value(value_t'({$urandom()} & 32'hFFFF_FFFE));
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_values();
    for (int i = 0; i < RandomWords; i++) begin
      no_idle = (i >= 30 && i < 50);
      offer_value(random_value());
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_values();
    test_sender_pause();
    test_output_hold_off();
    test_random_values();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d words and checked %0d results: values below two, even, prime,",
             words_sent, results_checked);
    $display("prime squares and products of small factors, with output hold-off and pauses.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: random ready with gaps, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request > 0) begin
        stall_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  // Outputs are stable at the falling edge; a word seen here is taken at the next rising edge.
  initial begin
    split_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_splits.size() == 0) begin
          report_mismatch("unexpected result", '0, quotient_o, '0);
        end else begin
          want = expected_splits.pop_front();
          if (quotient_o !== want.quotient)
            report_mismatch("quotient", want.value, quotient_o, want.quotient);
          if (smallest_factor_o !== want.factor)
            report_mismatch("smallest_factor", want.value, smallest_factor_o, want.factor);
          results_checked++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_splits.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/smpf_pkg.sv
sv/smpf_divider.sv
sv/smallest_prime_factor_divide.sv
tb/smallest_prime_factor_divide_test.sv
